/* hw/rtl/bsdi_pkg.sv */
// ----------------------------------------------------------------------------
// bsdi_pkg: shared types and constants
// Field widths, command codes and the control bundles between the top
// level, the list cells and the bounding box axes.
// ----------------------------------------------------------------------------
package bsdi_pkg;

  localparam int DEPTH_W  = 24;
  localparam int OWNER_W  = 16;
  localparam int COORD_W  = 24;
  localparam int RADIUS_W = 23;
  localparam int RIDX_W   = 4;
  localparam int TOTAL_W  = 5;
  localparam int LIMIT_W  = 5;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

  localparam logic signed [COORD_W-1:0] BOX_POS_MAX = 24'sh7FFFFF;
  localparam logic signed [COORD_W-1:0] BOX_NEG_MIN = 24'sh800000;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_READ   = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  // Register index decoded from the configuration address.
  typedef enum logic {
    REG_MAX_ENTRIES = 1'b0,
    REG_UNUSED      = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic insert;       // insert beat accepted this cycle
    logic below_count;  // cell holds a counted entry
    logic below_limit;  // cell lies under the capacity limit
    logic at_tail;      // cell sits right after the last counted entry
  } cell_ctl_t;

  typedef struct packed {
    logic clear;
    logic insert;
  } box_ctl_t;

endpackage

/* hw/rtl/bsdi_in_if.sv */
// ----------------------------------------------------------------------------
// bsdi_in_if: command channel
// Valid/ready channel carrying one command beat with its operands.
// ----------------------------------------------------------------------------
interface bsdi_in_if
  import bsdi_pkg::*;
;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 cmd;
  logic [DEPTH_W-1:0]         depth;
  logic [OWNER_W-1:0]         owner_id;
  logic [RIDX_W-1:0]          read_index;
  logic signed [COORD_W-1:0]  centre_x;
  logic signed [COORD_W-1:0]  centre_y;
  logic signed [COORD_W-1:0]  centre_z;
  logic [RADIUS_W-1:0]        radius;

  modport source (
    output valid, cmd, depth, owner_id, read_index, centre_x, centre_y, centre_z,
           radius,
    input  ready
  );

  modport sink (
    input  valid, cmd, depth, owner_id, read_index, centre_x, centre_y, centre_z,
           radius,
    output ready
  );
endinterface

/* hw/rtl/bsdi_out_if.sv */
// ----------------------------------------------------------------------------
// bsdi_out_if: result channel
// Valid/ready channel carrying one result beat per command.
// ----------------------------------------------------------------------------
interface bsdi_out_if
  import bsdi_pkg::*;
;
  logic                       valid;
  logic                       ready;
  logic [TOTAL_W-1:0]         entry_total;
  logic                       was_inserted;
  logic [DEPTH_W-1:0]         read_depth;
  logic [OWNER_W-1:0]         read_owner;
  logic signed [COORD_W-1:0]  box_min_x;
  logic signed [COORD_W-1:0]  box_min_y;
  logic signed [COORD_W-1:0]  box_min_z;
  logic signed [COORD_W-1:0]  box_max_x;
  logic signed [COORD_W-1:0]  box_max_y;
  logic signed [COORD_W-1:0]  box_max_z;

  modport source (
    output valid, entry_total, was_inserted, read_depth, read_owner,
           box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
    input  ready
  );

  modport sink (
    input  valid, entry_total, was_inserted, read_depth, read_owner,
           box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
    output ready
  );
endinterface

/* hw/rtl/bounded_sorted_depth_insert_unit.sv */
// ----------------------------------------------------------------------------
// bounded_sorted_depth_insert_unit: bounded sorted depth list with box
// Result beats are registered: each appears in the cycle after its command beat is taken.
// Throughput: one command per cycle; the compare chain through all list cells
// settles within that cycle, and a stalled result only holds the next command.
// Reset clears the entry count, the box and the output valid, and sets the
// limit to 16; the list cells themselves are not cleared.
// ----------------------------------------------------------------------------
module bounded_sorted_depth_insert_unit
  import bsdi_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  bsdi_in_if.sink     in_ch,
  bsdi_out_if.source  out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;

  // Configuration
  logic [LIMIT_W-1:0] max_r, max_nxt;
  reg_idx_t           reg_sel;
  logic               cfg_wr;

  assign cfg_pready = 1'b1;
  assign reg_sel    = reg_idx_t'(cfg_paddr[2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    max_nxt = max_r;
    if (cfg_wr && reg_sel == REG_MAX_ENTRIES) begin
      max_nxt = cfg_pwdata[LIMIT_W-1:0];
    end
  end

  always_comb begin
    case (reg_sel)
      REG_MAX_ENTRIES: cfg_prdata = {{(32-LIMIT_W){1'b0}}, max_r};
      default:         cfg_prdata = '0;
    endcase
  end

  // Command decode
  cmd_t  cmd;
  logic  accept;
  logic  out_valid_r, out_valid_nxt;
  logic  do_insert, do_clear, do_read;

  assign cmd          = cmd_t'(in_ch.cmd);
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign accept       = in_ch.valid && in_ch.ready;
  assign do_insert    = accept && (cmd == CMD_INSERT);
  assign do_clear     = accept && (cmd == CMD_CLEAR);
  assign do_read      = accept && (cmd == CMD_READ);

  // Limit is the register saturated to the number of cells.
  logic [LW-1:0] max_ext;
  logic [CW-1:0] limit;
  logic [CW-1:0] count_r, count_nxt;

  assign max_ext = LW'(max_r);
  assign limit   = (max_ext < LW'(CAPACITY)) ? CW'(max_ext) : CW'(CAPACITY);

  // Cell chain
  logic [DEPTH_W-1:0] cell_depth [CAPACITY];
  logic [OWNER_W-1:0] cell_owner [CAPACITY];
  logic               found      [CAPACITY+1];
  logic [CAPACITY-1:0] took_new;
  cell_ctl_t          cell_ctl   [CAPACITY];

  assign found[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DEPTH_W-1:0] prev_d;
    logic [OWNER_W-1:0] prev_o;

    if (i == 0) begin : g_head
      assign prev_d = in_ch.depth;
      assign prev_o = in_ch.owner_id;
    end else begin : g_body
      assign prev_d = cell_depth[i-1];
      assign prev_o = cell_owner[i-1];
    end

    assign cell_ctl[i].insert      = do_insert;
    assign cell_ctl[i].below_count = (CW'(i) < count_r);
    assign cell_ctl[i].below_limit = (CW'(i) < limit);
    assign cell_ctl[i].at_tail     = (CW'(i) == count_r);

    bsdi_cell u_cell (
      .clk        (clk),
      .ctl        (cell_ctl[i]),
      .new_depth  (in_ch.depth),
      .new_owner  (in_ch.owner_id),
      .prev_depth (prev_d),
      .prev_owner (prev_o),
      .found_in   (found[i]),
      .found_out  (found[i+1]),
      .took_new   (took_new[i]),
      .depth_q    (cell_depth[i]),
      .owner_q    (cell_owner[i])
    );
  end

  logic inserted;
  assign inserted = |took_new;

  always_comb begin
    count_nxt = count_r;
    if (do_clear) begin
      count_nxt = '0;
    end else if (do_insert && inserted && (count_r < limit)) begin
      count_nxt = count_r + CW'(1);
    end
  end

  // Read select over the cells; an index past the count reads as zero.
  logic [DEPTH_W-1:0] sel_depth;
  logic [OWNER_W-1:0] sel_owner;
  logic [LW-1:0]      ridx_ext;

  assign ridx_ext = LW'(in_ch.read_index);

  always_comb begin
    sel_depth = '0;
    sel_owner = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if ((ridx_ext == LW'(i)) && (CW'(i) < count_r)) begin
        sel_depth = cell_depth[i];
        sel_owner = cell_owner[i];
      end
    end
  end

  // Bounding box axes
  box_ctl_t box_ctl;
  assign box_ctl.clear  = do_clear;
  assign box_ctl.insert = do_insert;

  bsdi_box_axis u_box_x (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (box_ctl),
    .centre (in_ch.centre_x),
    .radius (in_ch.radius),
    .low_q  (out_ch.box_min_x),
    .high_q (out_ch.box_max_x)
  );

  bsdi_box_axis u_box_y (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (box_ctl),
    .centre (in_ch.centre_y),
    .radius (in_ch.radius),
    .low_q  (out_ch.box_min_y),
    .high_q (out_ch.box_max_y)
  );

  bsdi_box_axis u_box_z (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (box_ctl),
    .centre (in_ch.centre_z),
    .radius (in_ch.radius),
    .low_q  (out_ch.box_min_z),
    .high_q (out_ch.box_max_z)
  );

  // Result beat. Count and box registers only move on an accepted beat, so
  // they stay put while a result is stalled.
  logic               ins_r, ins_nxt;
  logic [DEPTH_W-1:0] rd_depth_r, rd_depth_nxt;
  logic [OWNER_W-1:0] rd_owner_r, rd_owner_nxt;

  always_comb begin
    out_valid_nxt = out_valid_r;
    ins_nxt       = ins_r;
    rd_depth_nxt  = rd_depth_r;
    rd_owner_nxt  = rd_owner_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
      ins_nxt       = do_insert && inserted;
      rd_depth_nxt  = do_read ? sel_depth : '0;
      rd_owner_nxt  = do_read ? sel_owner : '0;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r       <= LIMIT_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      max_r       <= max_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ins_r      <= ins_nxt;
    rd_depth_r <= rd_depth_nxt;
    rd_owner_r <= rd_owner_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.entry_total  = TOTAL_W'(count_r);
  assign out_ch.was_inserted = ins_r;
  assign out_ch.read_depth   = rd_depth_r;
  assign out_ch.read_owner   = rd_owner_r;

endmodule

/* hw/rtl/bsdi_cell.sv */
// ----------------------------------------------------------------------------
// bsdi_cell: one slot of the sorted depth list
// Holds a depth/owner pair, compares it with the incoming depth and either
// keeps its pair, takes the new pair or takes its upper neighbor's pair.
// ----------------------------------------------------------------------------
module bsdi_cell
  import bsdi_pkg::*;
(
  input  logic               clk,
  input  cell_ctl_t          ctl,
  input  logic [DEPTH_W-1:0] new_depth,
  input  logic [OWNER_W-1:0] new_owner,
  input  logic [DEPTH_W-1:0] prev_depth,
  input  logic [OWNER_W-1:0] prev_owner,
  input  logic               found_in,
  output logic               found_out,
  output logic               took_new,
  output logic [DEPTH_W-1:0] depth_q,
  output logic [OWNER_W-1:0] owner_q
);

  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic [OWNER_W-1:0] owner_r, owner_nxt;
  logic               greater;
  logic               take_prev;

  // An earlier cell already holds a larger depth, so this cell shifts down.
  assign greater   = ctl.below_count && (new_depth < depth_r);
  assign found_out = found_in || greater;
  assign take_prev = ctl.insert && ctl.below_limit && found_in;
  assign took_new  = ctl.insert && ctl.below_limit && !found_in && (greater || ctl.at_tail);

  always_comb begin
    depth_nxt = depth_r;
    owner_nxt = owner_r;
    if (take_prev) begin
      depth_nxt = prev_depth;
      owner_nxt = prev_owner;
    end else if (took_new) begin
      depth_nxt = new_depth;
      owner_nxt = new_owner;
    end
  end

  always_ff @(posedge clk) begin
    depth_r <= depth_nxt;
    owner_r <= owner_nxt;
  end

  assign depth_q = depth_r;
  assign owner_q = owner_r;

endmodule

/* hw/rtl/bsdi_box_axis.sv */
// ----------------------------------------------------------------------------
// bsdi_box_axis: one axis of the running bounding box
// Widens the low and high bounds by centre minus and plus radius, with the
// bounds saturated to the signed 24-bit range.
// ----------------------------------------------------------------------------
module bsdi_box_axis
  import bsdi_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  box_ctl_t                  ctl,
  input  logic signed [COORD_W-1:0] centre,
  input  logic [RADIUS_W-1:0]       radius,
  output logic signed [COORD_W-1:0] low_q,
  output logic signed [COORD_W-1:0] high_q
);

  localparam int SUM_W = COORD_W + 2;

  logic signed [COORD_W-1:0] low_r, low_nxt;
  logic signed [COORD_W-1:0] high_r, high_nxt;
  logic signed [SUM_W-1:0]   c_ext;
  logic signed [SUM_W-1:0]   r_ext;
  logic signed [SUM_W-1:0]   lo_sum;
  logic signed [SUM_W-1:0]   hi_sum;
  logic signed [COORD_W-1:0] lo_sat;
  logic signed [COORD_W-1:0] hi_sat;

  assign c_ext  = SUM_W'(centre);
  assign r_ext  = $signed({{(SUM_W-RADIUS_W){1'b0}}, radius});
  assign lo_sum = c_ext - r_ext;
  assign hi_sum = c_ext + r_ext;

  // The lower bound can only fall below the range, the upper only rise above.
  assign lo_sat = (lo_sum < SUM_W'(BOX_NEG_MIN)) ? BOX_NEG_MIN : COORD_W'(lo_sum);
  assign hi_sat = (hi_sum > SUM_W'(BOX_POS_MAX)) ? BOX_POS_MAX : COORD_W'(hi_sum);

  always_comb begin
    low_nxt  = low_r;
    high_nxt = high_r;
    if (ctl.clear) begin
      low_nxt  = BOX_POS_MAX;
      high_nxt = BOX_NEG_MIN;
    end else if (ctl.insert) begin
      if (lo_sat < low_r) begin
        low_nxt = lo_sat;
      end
      if (hi_sat > high_r) begin
        high_nxt = hi_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r  <= BOX_POS_MAX;
      high_r <= BOX_NEG_MIN;
    end else begin
      low_r  <= low_nxt;
      high_r <= high_nxt;
    end
  end

  assign low_q  = low_r;
  assign high_q = high_r;

endmodule

/* bench/bsdi_list_checker.sv */
// ----------------------------------------------------------------------------
// bsdi_list_checker: result checker for the sorted depth list
// Watches the command, result and configuration ports. It keeps its own copy
// of the sorted list, the entry count, the bounding box and the limit, works
// out the result of each command beat as it is taken, and compares each
// result beat, field by field, with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module bsdi_list_checker
  import bsdi_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  bsdi_in_if          in_mon,
  bsdi_out_if         out_mon,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic [31:0] cfg_prdata,
  input  logic        cfg_pready,
  output int          mismatch_count,
  output int          outstanding_count
);

  localparam logic [2:0] MAX_ENTRIES_ADDR = 3'(4 * int'(REG_MAX_ENTRIES));

  typedef struct packed {
    logic [TOTAL_W-1:0]          entry_total;
    logic                        was_inserted;
    logic [DEPTH_W-1:0]          read_depth;
    logic [OWNER_W-1:0]          read_owner;
    logic [2:0][COORD_W-1:0]     box_min;
    logic [2:0][COORD_W-1:0]     box_max;
  } list_result_t;

  logic [DEPTH_W-1:0]        depth_slot [CAPACITY];
  logic [OWNER_W-1:0]        owner_slot [CAPACITY];
  int                        held_count;
  logic signed [COORD_W-1:0] box_lo [3];
  logic signed [COORD_W-1:0] box_hi [3];
  logic [LIMIT_W-1:0]        limit_reg;
  list_result_t              pending_results [$];
  list_result_t              want;
  list_result_t              got;
  int                        fail_total = 0;

  initial begin
    mismatch_count    = 0;
    outstanding_count = 0;
  end

  function automatic int clamp_coord(int v);
    if (v > int'(BOX_POS_MAX)) return int'(BOX_POS_MAX);
    if (v < int'(BOX_NEG_MIN)) return int'(BOX_NEG_MIN);
    return v;
  endfunction

  task automatic empty_list();
    held_count = 0;
    for (int k = 0; k < 3; k++) begin
      box_lo[k] = BOX_POS_MAX;
      box_hi[k] = BOX_NEG_MIN;
    end
  endtask

  // Sorted insertion under the current limit. The search covers every counted
  // entry even when the limit has been lowered below the count.
  function automatic logic store_depth(logic [DEPTH_W-1:0] d, logic [OWNER_W-1:0] own);
    int lim;
    int n;
    int pos;
    int moved;
    lim = (int'(limit_reg) < CAPACITY) ? int'(limit_reg) : CAPACITY;
    n   = (held_count < CAPACITY) ? held_count : CAPACITY;
    pos = n;
    for (int i = 0; i < n; i++) begin
      if (pos == n && d < depth_slot[i]) pos = i;
    end
    if (pos >= lim) return 1'b0;
    if (n > pos) begin
      moved = n - pos;
      if (moved > lim - (pos + 1)) moved = lim - (pos + 1);
      for (int i = pos + moved; i > pos; i--) begin
        depth_slot[i] = depth_slot[i-1];
        owner_slot[i] = owner_slot[i-1];
      end
    end
    if (held_count < lim) held_count++;
    depth_slot[pos] = d;
    owner_slot[pos] = own;
    return 1'b1;
  endfunction

  task automatic predict_list_step(output list_result_t res);
    int c;
    int r;
    int lo;
    int hi;
    logic signed [COORD_W-1:0] centre [3];
    res = '0;
    centre[0] = in_mon.centre_x;
    centre[1] = in_mon.centre_y;
    centre[2] = in_mon.centre_z;
    case (in_mon.cmd)
      CMD_CLEAR: empty_list();
      CMD_INSERT: begin
        r = int'(in_mon.radius);
        for (int k = 0; k < 3; k++) begin
          c  = int'(centre[k]);
          lo = clamp_coord(c - r);
          hi = clamp_coord(c + r);
          if (lo < int'(box_lo[k])) box_lo[k] = COORD_W'(lo);
          if (hi > int'(box_hi[k])) box_hi[k] = COORD_W'(hi);
        end
        res.was_inserted = store_depth(in_mon.depth, in_mon.owner_id);
      end
      CMD_READ: begin
        if (int'(in_mon.read_index) < held_count && int'(in_mon.read_index) < CAPACITY) begin
          res.read_depth = depth_slot[in_mon.read_index];
          res.read_owner = owner_slot[in_mon.read_index];
        end
      end
      default: ;
    endcase
    res.entry_total = TOTAL_W'(held_count);
    for (int k = 0; k < 3; k++) begin
      res.box_min[k] = box_lo[k];
      res.box_max[k] = box_hi[k];
    end
  endtask

  function automatic void check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (act_val !== exp_val) begin
      fail_total++;
      $display("%0t: mismatch on %s: expected %h, actual %h", $time, name, exp_val, act_val);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      empty_list();
      limit_reg = LIMIT_RESET;
      pending_results.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pready && cfg_paddr == MAX_ENTRIES_ADDR) begin
        if (cfg_pwrite) begin
          limit_reg = cfg_pwdata[LIMIT_W-1:0];
        end else begin
          check_field("max_entries read-back", 32'(limit_reg), 32'(cfg_prdata[LIMIT_W-1:0]));
        end
      end

      if (out_mon.valid && out_mon.ready) begin
        got.entry_total  = out_mon.entry_total;
        got.was_inserted = out_mon.was_inserted;
        got.read_depth   = out_mon.read_depth;
        got.read_owner   = out_mon.read_owner;
        got.box_min[0]   = out_mon.box_min_x;
        got.box_min[1]   = out_mon.box_min_y;
        got.box_min[2]   = out_mon.box_min_z;
        got.box_max[0]   = out_mon.box_max_x;
        got.box_max[1]   = out_mon.box_max_y;
        got.box_max[2]   = out_mon.box_max_z;
        if (pending_results.size() == 0) begin
          fail_total++;
          $display("%0t: result beat with nothing outstanding, actual %h", $time, got);
        end else begin
          want = pending_results.pop_front();
          check_field("entry_total", 32'(want.entry_total), 32'(got.entry_total));
          check_field("was_inserted", 32'(want.was_inserted), 32'(got.was_inserted));
          check_field("read_depth", 32'(want.read_depth), 32'(got.read_depth));
          check_field("read_owner", 32'(want.read_owner), 32'(got.read_owner));
          for (int k = 0; k < 3; k++) begin
            check_field($sformatf("box_min[%0d]", k), 32'(want.box_min[k]), 32'(got.box_min[k]));
            check_field($sformatf("box_max[%0d]", k), 32'(want.box_max[k]), 32'(got.box_max[k]));
          end
        end
      end

      if (in_mon.valid && in_mon.ready) begin
        predict_list_step(want);
        pending_results.push_back(want);
      end
    end
    mismatch_count    <= fail_total;
    outstanding_count <= pending_results.size();
  end

endmodule

/* bench/tb_bounded_sorted_depth_insert_unit.sv */
// ----------------------------------------------------------------------------
// tb_bounded_sorted_depth_insert_unit: testbench for the sorted depth list
// Drives command beats and limit writes into the block, with random gaps on
// the command side and random stalls on the result side, including one long
// stall that backs the block up. A directed opening covers the extremes and
// corner cases; random phases follow, each after a limit write. The checker
// beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_bounded_sorted_depth_insert_unit
  import bsdi_pkg::*;
;

  localparam int CAPACITY    = 16;
  localparam int CYCLE_LIMIT = 500000;
  localparam int LONG_HOLD   = 300;
  localparam int PHASES      = 13;
  localparam int PHASE_BEATS = 50;

  localparam logic [2:0] MAX_ENTRIES_ADDR = 3'(4 * int'(REG_MAX_ENTRIES));

  typedef struct packed {
    cmd_t                cmd;
    logic [DEPTH_W-1:0]  depth;
    logic [OWNER_W-1:0]  owner_id;
    logic [RIDX_W-1:0]   read_index;
    logic [COORD_W-1:0]  centre_x;
    logic [COORD_W-1:0]  centre_y;
    logic [COORD_W-1:0]  centre_z;
    logic [RADIUS_W-1:0] radius;
  } command_beat_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  int          mismatch_count;
  int          outstanding_count;
  int          cycle_count = 0;
  bit          gaps_on = 1'b1;
  bit          hold_request = 1'b0;

  bsdi_in_if  in_bus ();
  bsdi_out_if out_bus ();

  bounded_sorted_depth_insert_unit #(
    .CAPACITY (CAPACITY)
  ) i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_bus),
    .out_ch      (out_bus),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  bsdi_list_checker #(
    .CAPACITY (CAPACITY)
  ) i_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_mon            (in_bus),
    .out_mon           (out_bus),
    .cfg_psel          (cfg_psel),
    .cfg_penable       (cfg_penable),
    .cfg_pwrite        (cfg_pwrite),
    .cfg_paddr         (cfg_paddr),
    .cfg_pwdata        (cfg_pwdata),
    .cfg_prdata        (cfg_prdata),
    .cfg_pready        (cfg_pready),
    .mismatch_count    (mismatch_count),
    .outstanding_count (outstanding_count)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Depths lean toward a small pool so that equal depths are common.
  function automatic command_beat_t random_fields(cmd_t cmd);
    command_beat_t b;
    int unsigned   sel;
    b.cmd        = cmd;
    b.owner_id   = OWNER_W'($urandom());
    b.read_index = RIDX_W'($urandom());
    sel = $urandom_range(0, 99);
    if (sel < 30)      b.depth = DEPTH_W'($urandom_range(0, 7));
    else if (sel < 80) b.depth = DEPTH_W'($urandom());
    else if (sel < 90) b.depth = '0;
    else               b.depth = '1;
    b.centre_x = COORD_W'($urandom());
    b.centre_y = COORD_W'($urandom());
    b.centre_z = COORD_W'($urandom());
    sel = $urandom_range(0, 99);
    if (sel < 10) b.centre_x = BOX_POS_MAX;
    else if (sel < 20) b.centre_y = BOX_NEG_MIN;
    else if (sel < 25) b.centre_z = BOX_POS_MAX;
    sel = $urandom_range(0, 99);
    if (sel < 70) b.radius = RADIUS_W'($urandom_range(0, 1023));
    else          b.radius = RADIUS_W'($urandom());
    return b;
  endfunction

  function automatic command_beat_t make_insert(logic [DEPTH_W-1:0] d, logic [OWNER_W-1:0] own,
                                                logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
                                                logic [COORD_W-1:0] cz, logic [RADIUS_W-1:0] r);
    command_beat_t b;
    b          = random_fields(CMD_INSERT);
    b.depth    = d;
    b.owner_id = own;
    b.centre_x = cx;
    b.centre_y = cy;
    b.centre_z = cz;
    b.radius   = r;
    return b;
  endfunction

  function automatic command_beat_t make_read(logic [RIDX_W-1:0] idx);
    command_beat_t b;
    b            = random_fields(CMD_READ);
    b.read_index = idx;
    return b;
  endfunction

  // Mostly well-formed inserts and reads; clears are rare so the list fills.
  function automatic command_beat_t random_beat();
    command_beat_t b;
    int unsigned   sel;
    b   = random_fields(CMD_INSERT);
    sel = $urandom_range(0, 99);
    if (sel < 4)       b.cmd = CMD_CLEAR;
    else if (sel < 15) b.cmd = CMD_NOP;
    else if (sel < 40) b.cmd = CMD_READ;
    return b;
  endfunction

  function automatic logic [LIMIT_W-1:0] phase_limit(int p);
    case (p)
      0:       return 5'd16;
      1:       return 5'd5;
      2:       return 5'd31;
      3:       return 5'd12;
      4:       return 5'd1;
      5:       return 5'd16;
      6:       return 5'd16;
      7:       return 5'd0;
      8:       return 5'd2;
      9:       return 5'd31;
      default: return LIMIT_W'($urandom_range(0, 31));
    endcase
  endfunction

  // Starts and ends on a rising edge. With no gap, valid simply stays high.
  task automatic offer_beat(input command_beat_t b);
    int unsigned gap;
    int unsigned sel;
    gap = 0;
    if (gaps_on) begin
      sel = $urandom_range(0, 99);
      if (sel >= 98)      gap = $urandom_range(20, 40);
      else if (sel >= 90) gap = $urandom_range(3, 8);
      else if (sel >= 70) gap = $urandom_range(1, 2);
    end
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.cmd        <= b.cmd;
    in_bus.depth      <= b.depth;
    in_bus.owner_id   <= b.owner_id;
    in_bus.read_index <= b.read_index;
    in_bus.centre_x   <= b.centre_x;
    in_bus.centre_y   <= b.centre_y;
    in_bus.centre_z   <= b.centre_z;
    in_bus.radius     <= b.radius;
    do begin
      @(posedge clk);
    end while (in_bus.ready !== 1'b1);
  endtask

  task automatic drain_results();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (outstanding_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write the limit, then read it straight back while psel stays high.
  task automatic program_limit(input logic [LIMIT_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= MAX_ENTRIES_ADDR;
    cfg_pwdata  <= {27'($urandom()), value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Result side: mostly ready, short and occasional long stalls, and one
  // long hold-off on request while the command side keeps offering.
  initial begin
    int unsigned sel;
    int unsigned span;
    logic        level;
    out_bus.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_bus.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        sel = $urandom_range(0, 99);
        if (sel < 55) begin
          level = 1'b1;
          span  = $urandom_range(1, 12);
        end else if (sel < 85) begin
          level = 1'b0;
          span  = $urandom_range(1, 3);
        end else if (sel < 95) begin
          level = 1'b0;
          span  = $urandom_range(4, 12);
        end else if (sel < 98) begin
          level = 1'b0;
          span  = $urandom_range(20, 60);
        end else begin
          level = 1'b1;
          span  = $urandom_range(80, 200);
        end
        out_bus.ready <= level;
        repeat (span) @(posedge clk);
      end
    end
  end

  initial begin
    rst_n             <= 1'b0;
    cfg_psel          <= 1'b0;
    cfg_penable       <= 1'b0;
    cfg_pwrite        <= 1'b0;
    cfg_paddr         <= '0;
    cfg_pwdata        <= '0;
    in_bus.valid      <= 1'b0;
    in_bus.cmd        <= CMD_NOP;
    in_bus.depth      <= '0;
    in_bus.owner_id   <= '0;
    in_bus.read_index <= '0;
    in_bus.centre_x   <= '0;
    in_bus.centre_y   <= '0;
    in_bus.centre_z   <= '0;
    in_bus.radius     <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty list and box straight out of reset, then ordering and equal depths.
    offer_beat(make_read(4'd0));
    offer_beat(random_fields(CMD_NOP));
    offer_beat(make_insert(24'h800000, 16'h1234, 24'h000000, 24'h000000, 24'h000000, 23'h0));
    offer_beat(make_insert(24'h000000, 16'h0000, 24'h000064, 24'hFFFF9C, 24'h000005, 23'h10));
    offer_beat(make_insert(24'hFFFFFF, 16'hFFFF, 24'h123456, 24'hABCDEF, 24'h000100, 23'h100));
    offer_beat(make_insert(24'h800000, 16'hAAAA, 24'hFFFFFF, 24'h000001, 24'h400000, 23'h55));
    // Box saturation at both ends on every axis.
    offer_beat(make_insert(24'h400000, 16'h5555, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 23'h7FFFFF));
    offer_beat(make_insert(24'h400000, 16'h5556, 24'h800000, 24'h800000, 24'h800000, 23'h7FFFFF));
    for (int i = 0; i < 4; i++) offer_beat(make_read(RIDX_W'(i)));
    offer_beat(make_read(4'hF));
    offer_beat(random_fields(CMD_CLEAR));
    offer_beat(make_read(4'd0));
    offer_beat(random_fields(CMD_NOP));

    // A single slot: a smaller depth displaces the held one, a larger is dropped.
    drain_results();
    program_limit(5'd1);
    offer_beat(make_insert(24'h000050, 16'h0050, 24'h000010, 24'h000020, 24'h000030, 23'h4));
    offer_beat(make_insert(24'h000010, 16'h0010, 24'hFFFFF0, 24'h000000, 24'h000000, 23'h4));
    offer_beat(make_insert(24'h000060, 16'h0060, 24'h000000, 24'hFFFFE0, 24'h000000, 23'h4));
    offer_beat(make_read(4'd0));

    // Zero limit stores nothing but still widens the box.
    drain_results();
    program_limit(5'd0);
    offer_beat(make_insert(24'h000001, 16'h0001, 24'h000200, 24'h000200, 24'hFFFE00, 23'h80));
    offer_beat(make_read(4'd0));

    // A limit above capacity behaves as capacity.
    drain_results();
    program_limit(5'd31);
    offer_beat(random_fields(CMD_CLEAR));
    offer_beat(make_insert(24'h000123, 16'hBEEF, 24'h000000, 24'h000000, 24'h000000, 23'h1));
    offer_beat(make_read(4'd0));

    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      program_limit(phase_limit(p));
      gaps_on = (p != 6 && p != 10);
      // Offer the phase only once the result side has begun its long hold-off.
      if (p == 6) begin
        hold_request = 1'b1;
        wait (!hold_request);
      end
      repeat (PHASE_BEATS) offer_beat(random_beat());
    end

    drain_results();
    repeat (5) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/bsdi_pkg.sv
hw/rtl/bsdi_in_if.sv
hw/rtl/bsdi_out_if.sv
hw/rtl/bsdi_cell.sv
hw/rtl/bsdi_box_axis.sv
hw/rtl/bounded_sorted_depth_insert_unit.sv
bench/bsdi_list_checker.sv
bench/tb_bounded_sorted_depth_insert_unit.sv
